FILE: src/cdlt_pkg.sv
package cdlt_pkg;

    // Default sizes
    localparam int ENTRIES_DEF    = 16;
    localparam int NAME_BYTES_DEF = 8;

    // Default names, first character in the low byte
    localparam logic [63:0] NAME_KILL = 64'h0000_0000_4C4C_494B;
    localparam logic [63:0] NAME_EXEC = 64'h0000_0000_4345_5845;

    // Operation codes
    localparam logic [2:0] OP_LOOKUP  = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_RESTORE = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    // Key unit status towards the sequencer
    typedef struct packed {
        logic matchable;
        logic eq;
    } t_key_stat;

    // Position of the first zero byte, 8 when there is none
    function automatic logic [3:0] zero_pos(input logic [63:0] v);
        logic [3:0] p;
        p = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (v[8*i +: 8] == 8'h00) p = 4'(i);
        end
        return p;
    endfunction

    // Keep the low n bytes, clear the rest
    function automatic logic [63:0] low_bytes(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) r[8*i +: 8] = v[8*i +: 8];
        end
        return r;
    endfunction

    // Name as it is stored: at most nb-1 characters
    function automatic logic [63:0] stored_form(input logic [63:0] v, input int nb);
        logic [3:0] p;
        p = zero_pos(v);
        if (32'(p) > nb - 1) p = 4'(nb - 1);
        return low_bytes(v, p);
    endfunction

endpackage

FILE: src/command_deny_list_table_unit.sv
// Command deny-list table.
// Input channel: i_valid / o_stall with i_op, i_cmd_name, i_entry_index; a beat is
// taken when i_valid is high and o_stall low. Output channel: o_valid / i_stall with
// o_status, o_hit, o_entry_count, o_entry_name; one result beat per input beat.
// Names live in a single-port-read memory; lookup, add and remove scan it one entry
// per cycle through one shared comparator, and remove then shifts later entries down
// one per cycle over the same port.
// From one input beat to the next: lookup, add and remove scan the live entries (an
// empty table or an unterminated name ends the scan at once), remove of a present
// name then shifts the later entries; read goes through S_READ, clear and unused
// codes go straight to S_DONE, restore passes S_INIT0 and S_INIT1. The result beat
// appears in the same cycle that the next beat can be taken. The memory read port sets the pace.
// The block takes one item at a time; o_stall is high while it works.
// Reset: S_INIT0 and S_INIT1 write the defaults KILL and EXEC, count becomes 2, and
// o_stall stays high until they end.
// Receiver stall: the result waits in the output register; the block may take and
// finish one more item, which then waits until the output register is free.
module command_deny_list_table_unit #(
    parameter int ENTRIES    = cdlt_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = cdlt_pkg::NAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_cmd_name,
    input  logic [3:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_hit,
    output logic [4:0]  o_entry_count,
    output logic [63:0] o_entry_name
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [63:0] KILL_S = cdlt_pkg::stored_form(cdlt_pkg::NAME_KILL, NAME_BYTES);
    localparam logic [63:0] EXEC_S = cdlt_pkg::stored_form(cdlt_pkg::NAME_EXEC, NAME_BYTES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT0 = 7'b0000010,
        S_INIT1 = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_op, n_op;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_idx, n_pend_idx;
    logic                r_boot, n_boot;
    logic [1:0]          r_status, n_status;
    logic                r_hit, n_hit;
    logic [63:0]         r_rname, n_rname;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic                r_out_hit, n_out_hit;
    logic [4:0]          r_out_count, n_out_count;
    logic [63:0]         r_out_name, n_out_name;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [63:0]         mem_wdata, mem_rdata;
    logic                key_load;
    cdlt_pkg::t_key_stat key_stat;
    logic [63:0]         key_stored;
    logic                found, search_end;

    cdlt_name_mem #(.DEPTH(ENTRIES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cdlt_key_unit #(.NAME_BYTES(NAME_BYTES)) u_key (
        .i_clk    (i_clk),
        .i_load   (key_load),
        .i_name   (i_cmd_name),
        .i_rdata  (mem_rdata),
        .o_stat   (key_stat),
        .o_stored (key_stored)
    );

    assign found      = r_pend && key_stat.eq;
    assign search_end = !r_pend && (!key_stat.matchable || (r_rd_idx >= r_count));

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_boot       = r_boot;
        n_status     = r_status;
        n_hit        = r_hit;
        n_rname      = r_rname;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_hit    = r_out_hit;
        n_out_count  = r_out_count;
        n_out_name   = r_out_name;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        key_load     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    key_load = 1'b1;
                    n_op     = i_op;
                    n_status = cdlt_pkg::ST_OK;
                    n_hit    = 1'b0;
                    n_rname  = '0;
                    n_rd_idx = '0;
                    case (i_op)
                        cdlt_pkg::OP_LOOKUP,
                        cdlt_pkg::OP_ADD,
                        cdlt_pkg::OP_REMOVE: n_state = S_SCAN;
                        cdlt_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        cdlt_pkg::OP_RESTORE: n_state = S_INIT0;
                        cdlt_pkg::OP_READ: begin
                            if (32'(i_entry_index) < 32'(r_count)) begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(i_entry_index);
                                n_state   = S_READ;
                            end else begin
                                n_status = cdlt_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            // Load the two default names
            S_INIT0: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(0);
                mem_wdata = KILL_S;
                n_state   = S_INIT1;
            end
            S_INIT1: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(1);
                mem_wdata = EXEC_S;
                n_count   = CW'(2);
                n_boot    = 1'b0;
                n_state   = r_boot ? S_IDLE : S_DONE;
            end

            // One entry a cycle through the comparator
            S_SCAN: begin
                if (found) begin
                    n_hit = 1'b1;
                    if (r_op == cdlt_pkg::OP_REMOVE) begin
                        n_rd_idx = CW'(r_pend_idx) + CW'(1);
                        n_state  = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (search_end) begin
                    case (r_op)
                        cdlt_pkg::OP_ADD: begin
                            if (r_count == CW'(ENTRIES)) begin
                                n_status = cdlt_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = key_stored;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        cdlt_pkg::OP_REMOVE: n_status = cdlt_pkg::ST_ABSENT;
                        default: ;
                    endcase
                    n_state = S_DONE;
                end else if (key_stat.matchable && (r_rd_idx < r_count)) begin
                    mem_re     = 1'b1;
                    mem_raddr  = r_rd_idx[AW-1:0];
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[AW-1:0];
                    n_rd_idx   = r_rd_idx + CW'(1);
                end
            end

            // Close the gap: read entry j+1, write it to j next cycle
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pend_idx - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (r_rd_idx < r_count) begin
                    mem_re     = 1'b1;
                    mem_raddr  = r_rd_idx[AW-1:0];
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[AW-1:0];
                    n_rd_idx   = r_rd_idx + CW'(1);
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_READ: begin
                n_rname = mem_rdata;
                n_state = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_hit    = r_hit;
                    n_out_count  = 5'(r_count);
                    n_out_name   = r_rname;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_rd_idx     <= n_rd_idx;
        r_pend_idx   <= n_pend_idx;
        r_status     <= n_status;
        r_hit        <= n_hit;
        r_rname      <= n_rname;
        r_out_status <= n_out_status;
        r_out_hit    <= n_out_hit;
        r_out_count  <= n_out_count;
        r_out_name   <= n_out_name;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_hit         = r_out_hit;
    assign o_entry_count = r_out_count;
    assign o_entry_name  = r_out_name;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table size");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside done state");

    a_shift_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend) |-> (CW'(r_pend_idx) < r_count && r_pend_idx != '0))
        else $error("shift write outside valid entries");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_valid) |=> $stable(r_count))
        else $error("count changed with no beat taken");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> $stable(r_count))
        else $error("count changed while result pending");
`endif

endmodule

FILE: src/cdlt_name_mem.sv
module cdlt_name_mem #(
    parameter int DEPTH = cdlt_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [63:0]                i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [63:0]                o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cdlt_key_unit.sv
module cdlt_key_unit #(
    parameter int NAME_BYTES = cdlt_pkg::NAME_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [63:0]           i_name,
    input  logic [63:0]           i_rdata,
    output cdlt_pkg::t_key_stat   o_stat,
    output logic [63:0]           o_stored
);

    logic [3:0]  zpos;
    logic [63:0] r_key;
    logic [63:0] r_stored;
    logic        r_matchable;

    assign zpos = cdlt_pkg::zero_pos(i_name);

    // Capture search key and stored form when a beat is taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key       <= cdlt_pkg::low_bytes(i_name, zpos);
            r_stored    <= cdlt_pkg::stored_form(i_name, NAME_BYTES);
            r_matchable <= (32'(zpos) < NAME_BYTES);
        end
    end

    // Shared comparator against the entry read back
    assign o_stat.matchable = r_matchable;
    assign o_stat.eq        = (i_rdata == r_key);
    assign o_stored         = r_stored;

endmodule

FILE: dv/command_deny_list_table_checker.sv
// Watches both channels of the deny-list table, predicts each result beat and
// compares it field by field with what the block returns.
module command_deny_list_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_cmd_name,
    input  logic [3:0]  i_entry_index,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  logic [1:0]  i_status,
    input  logic        i_hit,
    input  logic [4:0]  i_entry_count,
    input  logic [63:0] i_entry_name,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = cdlt_pkg::ENTRIES_DEF;
    localparam int NB    = cdlt_pkg::NAME_BYTES_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [4:0]  count;
        logic [63:0] name;
    } t_table_reply;

    // Shadow copy of the table
    logic [63:0]  deny_names [SLOTS];
    int unsigned  deny_used;
    t_table_reply replies_due [$];
    int           fail_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = replies_due.size();

    // Byte index of the first NUL, 8 if the word has none
    function automatic int unsigned first_nul(input logic [63:0] v);
        for (int i = 0; i < 8; i++) begin
            if (v[8*i +: 8] == 8'h00) return i;
        end
        return 8;
    endfunction

    function automatic logic [63:0] keep_low(input logic [63:0] v, input int unsigned n);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < n) mask[8*i +: 8] = 8'hFF;
        end
        return v & mask;
    endfunction

    // What gets written on add: clipped to NB-1 characters
    function automatic logic [63:0] truncated(input logic [63:0] v);
        int unsigned p;
        p = first_nul(v);
        if (p > NB - 1) p = NB - 1;
        return keep_low(v, p);
    endfunction

    // First live slot holding the name, -1 if none or unterminated
    function automatic int find_slot(input logic [63:0] v);
        int unsigned p;
        logic [63:0] key;
        p = first_nul(v);
        if (p >= NB) return -1;
        key = keep_low(v, p);
        for (int i = 0; i < int'(deny_used) && i < SLOTS; i++) begin
            if (deny_names[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void load_defaults();
        deny_names[0] = truncated(cdlt_pkg::NAME_KILL);
        deny_names[1] = truncated(cdlt_pkg::NAME_EXEC);
        deny_used     = 2;
    endfunction

    // Apply one command to the shadow table and return the reply it should give
    function automatic t_table_reply apply_command(input logic [2:0] op,
                                                   input logic [63:0] name,
                                                   input logic [3:0] idx);
        t_table_reply r;
        int pos;
        r   = '0;
        pos = find_slot(name);
        case (op)
            cdlt_pkg::OP_LOOKUP: r.hit = (pos >= 0);
            cdlt_pkg::OP_ADD: begin
                if (pos >= 0) begin
                    r.hit = 1'b1;
                end else if (deny_used >= SLOTS) begin
                    r.status = cdlt_pkg::ST_FULL;
                end else begin
                    deny_names[deny_used] = truncated(name);
                    deny_used++;
                end
            end
            cdlt_pkg::OP_REMOVE: begin
                if (pos < 0) begin
                    r.status = cdlt_pkg::ST_ABSENT;
                end else begin
                    r.hit = 1'b1;
                    // close the gap
                    for (int j = pos; j + 1 < int'(deny_used); j++) begin
                        deny_names[j] = deny_names[j + 1];
                    end
                    deny_used--;
                end
            end
            cdlt_pkg::OP_CLEAR:   deny_used = 0;
            cdlt_pkg::OP_RESTORE: load_defaults();
            cdlt_pkg::OP_READ: begin
                if (idx < deny_used) r.name = deny_names[idx];
                else r.status = cdlt_pkg::ST_RANGE;
            end
            default: ;
        endcase
        r.count = 5'(deny_used);
        return r;
    endfunction

    // Result beats are checked before the request beat of the same edge is queued
    always @(posedge i_clk) begin : watch
        t_table_reply got;
        t_table_reply want;
        if (!i_rst_n) begin
            replies_due.delete();
            load_defaults();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got = {i_status, i_hit, i_entry_count, i_entry_name};
                if (replies_due.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_total++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_total++;
                    end
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        fail_total++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                        fail_total++;
                    end
                    if (got.name !== want.name) begin
                        $error("entry_name: expected %h, got %h", want.name, got.name);
                        fail_total++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                replies_due.push_back(apply_command(i_op, i_cmd_name, i_entry_index));
            end
        end
    end

endmodule

FILE: dv/command_deny_list_table_unit_test.sv
// Stimulus and verdict for the deny-list table; checking lives in the checker.
module command_deny_list_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Op codes the block leaves unused
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int          POOL_SIZE  = 24;
    localparam int          RAND_ITEMS = 2000;
    localparam int unsigned IDLE_LIMIT = 4000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [2:0]  i_op          = cdlt_pkg::OP_LOOKUP;
    logic [63:0] i_cmd_name    = '0;
    logic [3:0]  i_entry_index = '0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [1:0]  o_status;
    logic        o_hit;
    logic [4:0]  o_entry_count;
    logic [63:0] o_entry_name;

    int          fail_count;
    int          pending;
    int unsigned in_beats    = 0;
    int unsigned out_beats   = 0;
    int unsigned idle_cycles = 0;
    int unsigned calm_left   = 0;
    logic [63:0] name_pool [POOL_SIZE];

    command_deny_list_table_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_cmd_name    (i_cmd_name),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_hit         (o_hit),
        .o_entry_count (o_entry_count),
        .o_entry_name  (o_entry_name)
    );

    command_deny_list_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_op          (i_op),
        .i_cmd_name    (i_cmd_name),
        .i_entry_index (i_entry_index),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_status      (o_status),
        .i_hit         (o_hit),
        .i_entry_count (o_entry_count),
        .i_entry_name  (o_entry_name),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Beat counters and watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) in_beats <= in_beats + 1;
            if (o_valid && !i_stall) out_beats <= out_beats + 1;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IDLE_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // Receiver: quiet stretches, short stalls, the odd long one
    initial begin : sink_pacing
        int unsigned mode;
        int unsigned len;
        @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                i_stall <= 1'b0;
                len = $urandom_range(20, 80);
            end else begin
                len = (mode < 9) ? $urandom_range(1, 3) : $urandom_range(15, 40);
                i_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_stall <= 1'b0;
                len = $urandom_range(1, 6);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Short name of random nonzero characters, NUL padded
    function automatic logic [63:0] fresh_key();
        int unsigned len;
        logic [63:0] k;
        len = $urandom_range(0, 7);
        k = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < len) k[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        return k;
    endfunction

    // Same name with junk after the terminator
    function automatic logic [63:0] dressed(input logic [63:0] k);
        int p;
        logic [63:0] v;
        v = k;
        p = 8;
        for (int i = 7; i >= 0; i--) begin
            if (k[8*i +: 8] == 8'h00) p = i;
        end
        for (int i = p + 1; i < 8; i++) begin
            if ($urandom_range(0, 1)) v[8*i +: 8] = 8'($urandom);
        end
        return v;
    endfunction

    // Eight characters, no terminator; its clipped form joins the pool
    function automatic logic [63:0] long_name();
        logic [63:0] v;
        v = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            if (v[8*i +: 8] == 8'h00) v[8*i +: 8] = 8'h5A;
        end
        name_pool[$urandom_range(0, POOL_SIZE - 1)] = {8'h00, v[55:0]};
        return v;
    endfunction

    function automatic logic [63:0] pick_name();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return dressed(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
        if (r < 87) return long_name();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [2:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return cdlt_pkg::OP_ADD;
        if (r < 50) return cdlt_pkg::OP_LOOKUP;
        if (r < 70) return cdlt_pkg::OP_REMOVE;
        if (r < 88) return cdlt_pkg::OP_READ;
        if (r < 91) return cdlt_pkg::OP_CLEAR;
        if (r < 95) return cdlt_pkg::OP_RESTORE;
        return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    // Present one beat, hold it until taken, then maybe idle
    task automatic send_beat(input logic [2:0] op, input logic [63:0] name,
                             input logic [3:0] idx);
        int unsigned gap;
        i_valid       <= 1'b1;
        i_op          <= op;
        i_cmd_name    <= name;
        i_entry_index <= idx;
        do @(posedge i_clk); while (o_stall);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender off until every result beat is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (out_beats != in_beats);
    endtask

    initial begin : stimulus
        name_pool[0] = cdlt_pkg::NAME_KILL;
        name_pool[1] = cdlt_pkg::NAME_EXEC;
        for (int i = 2; i < POOL_SIZE; i++) name_pool[i] = fresh_key();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: defaults, idempotent add, clipping, empty name, shift, bounds
        send_beat(cdlt_pkg::OP_LOOKUP,  cdlt_pkg::NAME_KILL, 4'd0);
        send_beat(cdlt_pkg::OP_LOOKUP,  64'h5A00_0000_4345_5845, 4'd15);
        send_beat(cdlt_pkg::OP_LOOKUP,  64'h0000_0000_004C_494B, 4'd0);
        send_beat(cdlt_pkg::OP_ADD,     cdlt_pkg::NAME_KILL, 4'd0);
        send_beat(cdlt_pkg::OP_ADD,     64'h4847_4645_4443_4241, 4'd0);
        send_beat(cdlt_pkg::OP_LOOKUP,  64'h4847_4645_4443_4241, 4'd0);
        send_beat(cdlt_pkg::OP_LOOKUP,  64'h0047_4645_4443_4241, 4'd0);
        send_beat(cdlt_pkg::OP_ADD,     64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_beat(cdlt_pkg::OP_ADD,     64'h0, 4'd0);
        send_beat(cdlt_pkg::OP_LOOKUP,  64'h0, 4'd0);
        send_beat(cdlt_pkg::OP_LOOKUP,  64'hFFFF_FFFF_FFFF_FF00, 4'd0);
        send_beat(cdlt_pkg::OP_READ,    64'h0, 4'd0);
        send_beat(cdlt_pkg::OP_READ,    64'h0, 4'd4);
        send_beat(cdlt_pkg::OP_READ,    64'h0, 4'd5);
        send_beat(cdlt_pkg::OP_READ,    64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_beat(cdlt_pkg::OP_REMOVE,  cdlt_pkg::NAME_EXEC, 4'd0);
        send_beat(cdlt_pkg::OP_READ,    64'h0, 4'd1);
        send_beat(cdlt_pkg::OP_REMOVE,  64'h0000_0000_4550_4F4E, 4'd0);
        send_beat(OP_SPARE_LO, 64'h0, 4'd0);
        send_beat(OP_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_beat(cdlt_pkg::OP_CLEAR,   64'h0, 4'd0);
        send_beat(cdlt_pkg::OP_READ,    64'h0, 4'd0);
        send_beat(cdlt_pkg::OP_REMOVE,  cdlt_pkg::NAME_KILL, 4'd0);
        send_beat(cdlt_pkg::OP_RESTORE, 64'h0, 4'd0);
        send_beat(cdlt_pkg::OP_READ,    64'h0, 4'd1);
        drain();

        // Random traffic over a small name pool so the table fills and empties
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 250 == 125) drain();
            if (calm_left == 0 && $urandom_range(0, 49) == 0) begin
                calm_left = $urandom_range(20, 60);
            end
            if ($urandom_range(0, 49) == 0) begin
                name_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
            end
            send_beat(pick_op(), pick_name(), 4'($urandom_range(0, 15)));
        end
        i_valid <= 1'b0;

        // Let the last results out, then a short settle
        while (out_beats != in_beats) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
